/* sv/rpi_pkg.sv */
// Shared widths, register indexes and pipeline payload types for the
// ray/plane intersection block. Depends on nothing.
package rpi_pkg;

   // Coordinate format: signed fixed point, CW bits with FB fraction bits.
   localparam int CW = 32;
   localparam int FB = 16;

   // Quotient / distance width, and the widths of the exact arithmetic.
   localparam int QW = CW - 1;           // t_max, t_near, quotient bits
   localparam int DW = CW + 1;           // plane origin minus ray origin
   localparam int PW = DW + CW;          // one product
   localparam int SW = PW + 2;           // sum of three products
   localparam int NW = SW + FB;          // numerator magnitude after scaling
   localparam int RW = SW + 1;           // partial remainder
   localparam int XW = SW + QW + FB;     // range check compare width

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_NORMAL_X = 3'd3,
      CSR_NORMAL_Y = 3'd4,
      CSR_NORMAL_Z = 3'd5
   } csr_idx_type;

   // Opcodes of the input item.
   localparam logic OP_CLOSEST   = 1'b0;
   localparam logic OP_OCCLUSION = 1'b1;

   // Per-item facts that ride alongside the division.
   typedef struct packed {
      logic          op;
      logic [QW-1:0] tmax;
      logic          nneg;
      logic          dneg;
      logic          num_zero;
      logic          den_zero;
      logic          over;
   } side_type;

   // State of one item inside the divider.
   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QW-1:0] quo;
      logic [QW-1:0] low;
      logic [SW-1:0] den;
      side_type      side;
   } div_type;

endpackage

/* sv/rpi_req_if.sv */
// Request and result channel interfaces of the ray/plane intersection block.
// Depends on rpi_pkg for the coordinate widths.
interface rpi_req_if;
   import rpi_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic signed [CW-1:0] ray_origin_x;
   logic signed [CW-1:0] ray_origin_y;
   logic signed [CW-1:0] ray_origin_z;
   logic signed [CW-1:0] ray_dir_x;
   logic signed [CW-1:0] ray_dir_y;
   logic signed [CW-1:0] ray_dir_z;
   logic [QW-1:0]        t_max;

   modport source (output valid, opcode, ray_origin_x, ray_origin_y, ray_origin_z,
                   ray_dir_x, ray_dir_y, ray_dir_z, t_max, input ready);
   modport sink   (input valid, opcode, ray_origin_x, ray_origin_y, ray_origin_z,
                   ray_dir_x, ray_dir_y, ray_dir_z, t_max, output ready);
endinterface

interface rpi_rsp_if;
   import rpi_pkg::*;

   logic          valid;
   logic          ready;
   logic          hit;
   logic [QW-1:0] t_near;

   modport source (output valid, hit, t_near, input ready);
   modport sink   (input valid, hit, t_near, output ready);
endinterface

/* sv/rpi_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Depends on rpi_pkg for the payload types.
module rpi_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  rpi_pkg::div_type in_data,
   output logic             out_valid,
   output rpi_pkg::div_type out_data
);
   import rpi_pkg::*;

   logic    valid_ff [QW];
   div_type data_ff  [QW];
   div_type data_in  [QW];

   // Each stage shifts in one numerator bit and tries one subtraction.
   always_comb begin
      div_type       prev;
      logic [RW-1:0] shifted;
      for (int k = 0; k < QW; k++) begin
         prev    = (k == 0) ? in_data : data_ff[(k == 0) ? 0 : k - 1];
         shifted = {prev.rem[RW-2:0], prev.low[QW-1]};
         data_in[k]     = prev;
         data_in[k].low = {prev.low[QW-2:0], 1'b0};
         if (shifted >= RW'(prev.den)) begin
            data_in[k].rem = shifted - RW'(prev.den);
            data_in[k].quo = {prev.quo[QW-2:0], 1'b1};
         end else begin
            data_in[k].rem = shifted;
            data_in[k].quo = {prev.quo[QW-2:0], 1'b0};
         end
      end
   end

   // Valid bits travel with the data; the whole pipe holds on a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QW; k++) valid_ff[k] <= 1'b0;
      end else if (enable) begin
         for (int k = 0; k < QW; k++) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < QW; k++) data_ff[k] <= data_in[k];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_data  = data_ff[QW-1];

endmodule

/* sv/ray_plane_intersection_top.sv */
// Top level of the ray/plane intersection block: configuration registers,
// dot products, range check, divider and result stage.
// Depends on rpi_pkg, rpi_req_if, rpi_rsp_if and rpi_divider.
//
// Usage: each request item carries one ray (origin, direction, t_max) and an
// opcode; each one gives exactly one result item holding the hit flag and
// the distance t_near, which reads zero on a miss. Opcode closest-hit takes
// 0 <= t <= t_max, opcode occlusion takes 0 < t < t_max. The user must write
// the plane origin and normal through the csr_ port only while no item is
// in flight; the block itself does not enforce this. The pipeline has five
// front stages (difference, products, sums, magnitudes, range check), one
// divider stage per quotient bit, and the result register. It takes one item
// per cycle while the receiver does not stall, as the divider is fully
// pipelined. When the receiver stalls the whole pipeline holds and request
// ready falls, so nothing is lost or repeated. Reset empties the pipeline and
// restores the plane to the origin with normal (0, 0, 1.0).
module ray_plane_intersection_top (
   input  logic                         clock,
   input  logic                         reset,
   rpi_req_if.sink                      req_chan,
   rpi_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [rpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpi_pkg::CW-1:0]       csr_data
);
   import rpi_pkg::*;

   // Configuration registers.
   logic signed [CW-1:0] porg_ff [3];
   logic signed [CW-1:0] pnrm_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            porg_ff[i] <= '0;
            pnrm_ff[i] <= (i == 2) ? CW'(64'd1 << FB) : '0;
         end
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ORIGIN_X: porg_ff[0] <= csr_data;
            CSR_ORIGIN_Y: porg_ff[1] <= csr_data;
            CSR_ORIGIN_Z: porg_ff[2] <= csr_data;
            CSR_NORMAL_X: pnrm_ff[0] <= csr_data;
            CSR_NORMAL_Y: pnrm_ff[1] <= csr_data;
            CSR_NORMAL_Z: pnrm_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline advances whenever the result register is free or taken.
   logic enable;
   logic out_valid_ff;
   assign enable         = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic div_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage 1: plane origin minus ray origin.
   logic signed [DW-1:0] diff_ff [3];
   logic signed [CW-1:0] dir_ff  [3];
   logic                 op1_ff;
   logic [QW-1:0]        tmax1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff[0] <= DW'(porg_ff[0]) - DW'(req_chan.ray_origin_x);
         diff_ff[1] <= DW'(porg_ff[1]) - DW'(req_chan.ray_origin_y);
         diff_ff[2] <= DW'(porg_ff[2]) - DW'(req_chan.ray_origin_z);
         dir_ff[0]  <= req_chan.ray_dir_x;
         dir_ff[1]  <= req_chan.ray_dir_y;
         dir_ff[2]  <= req_chan.ray_dir_z;
         op1_ff     <= req_chan.opcode;
         tmax1_ff   <= req_chan.t_max;
      end
   end

   // Stage 2: the six products against the normal.
   logic signed [PW-1:0] pnum_ff [3];
   logic signed [PW-1:0] pden_ff [3];
   logic                 op2_ff;
   logic [QW-1:0]        tmax2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            pnum_ff[i] <= PW'(diff_ff[i]) * PW'(pnrm_ff[i]);
            pden_ff[i] <= PW'(dir_ff[i]) * PW'(pnrm_ff[i]);
         end
         op2_ff   <= op1_ff;
         tmax2_ff <= tmax1_ff;
      end
   end

   // Stage 3: exact dot products.
   logic signed [SW-1:0] num_ff, den_ff;
   logic                 op3_ff;
   logic [QW-1:0]        tmax3_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff   <= SW'(pnum_ff[0]) + SW'(pnum_ff[1]) + SW'(pnum_ff[2]);
         den_ff   <= SW'(pden_ff[0]) + SW'(pden_ff[1]) + SW'(pden_ff[2]);
         op3_ff   <= op2_ff;
         tmax3_ff <= tmax2_ff;
      end
   end

   // Stage 4: signs, magnitudes and zero tests.
   logic [SW-1:0] nmag_ff, dmag_ff;
   side_type      side4_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         nmag_ff           <= num_ff[SW-1] ? SW'(-num_ff) : SW'(num_ff);
         dmag_ff           <= den_ff[SW-1] ? SW'(-den_ff) : SW'(den_ff);
         side4_ff.op       <= op3_ff;
         side4_ff.tmax     <= tmax3_ff;
         side4_ff.nneg     <= num_ff[SW-1];
         side4_ff.dneg     <= den_ff[SW-1];
         side4_ff.num_zero <= (num_ff == '0);
         side4_ff.den_zero <= (den_ff == '0);
         side4_ff.over     <= 1'b0;
      end
   end

   // Stage 5: scale the numerator and check whether the quotient fits.
   logic [NW-1:0] scaled;
   logic          over;
   side_type      side5;
   div_type       div_in_ff;

   always_comb begin
      scaled     = NW'(nmag_ff) << FB;
      over       = XW'(scaled) >= (XW'(dmag_ff) << QW);
      side5      = side4_ff;
      side5.over = over;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_in_ff.rem  <= RW'(scaled >> QW);
         div_in_ff.quo  <= '0;
         div_in_ff.low  <= QW'(scaled);
         div_in_ff.den  <= dmag_ff;
         div_in_ff.side <= side5;
      end
   end

   div_type div_out;

   rpi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v5_ff),
      .in_data   (div_in_ff),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   // Result stage: bound tests on the exact quotient and remainder.
   logic          hit;
   logic          pos, nonneg, beyond;
   logic          hit_ff;
   logic [QW-1:0] t_near_ff;
   logic [QW-1:0] tmax_out_ff;

   always_comb begin
      side_type s;
      s      = div_out.side;
      pos    = !s.num_zero && (s.nneg == s.dneg);
      nonneg = s.num_zero || (s.nneg == s.dneg);
      beyond = s.over || (div_out.quo > s.tmax) ||
               ((div_out.quo == s.tmax) && (div_out.rem != '0));
      if (s.den_zero) begin
         hit = 1'b0;
      end else if (s.op == OP_CLOSEST) begin
         hit = nonneg && !beyond;
      end else begin
         hit = pos && !s.over && (div_out.quo < s.tmax);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff      <= hit;
         t_near_ff   <= hit ? div_out.quo : '0;
         tmax_out_ff <= div_out.side.tmax;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.hit    = hit_ff;
   assign rsp_chan.t_near = t_near_ff;

   // A miss always reports zero distance.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !hit_ff |-> t_near_ff == '0)
      else $error("miss reported with non-zero distance");

   // A hit never reports a distance beyond the ray's limit.
   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && hit_ff |-> t_near_ff <= tmax_out_ff)
      else $error("hit distance exceeds t_max");

   // The pipeline is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !v1_ff && !div_valid)
      else $error("pipeline not empty after reset");

   // A stalled result holds its payload while the front stages stand still.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> $stable(t_near_ff) && $stable(v5_ff))
      else $error("pipeline moved during a stall");

endmodule

/* test/tb_ray_plane_intersection_top.sv */
// Self-checking testbench for ray_plane_intersection_top: random and directed rays
// against an exact fixed-point model of the plane hit test.
// Depends on rpi_pkg, rpi_req_if, rpi_rsp_if and the block itself.
module tb_ray_plane_intersection_top;
   import rpi_pkg::*;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          DRAIN_CYCLES  = 45;
   localparam int          HOLD_CYCLES   = 300;
   localparam logic [2:0]  CSR_UNUSED_IDX = 3'd6;

   typedef struct {
      logic          op;
      logic [CW-1:0] ox, oy, oz;
      logic [CW-1:0] dx, dy, dz;
      logic [QW-1:0] tmax;
   } ray_type;

   typedef struct {
      logic          hit;
      logic [QW-1:0] t_near;
   } hit_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CW-1:0] csr_data;

   rpi_req_if req_bus ();
   rpi_rsp_if rsp_bus ();

   ray_plane_intersection_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow of the plane registers, indexed like the register file.
   logic [CW-1:0] plane_cfg [6];

   ray_type ray_queue [$];
   hit_type expected_hits [$];
   int   fail_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   cycle_count = 0;

   // Clock generation.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Exact signed dot products, magnitudes and the scaled quotient of one ray.
   function automatic void divide_ray(input ray_type r, output logic den_zero,
                                      output logic num_zero, output logic same_sign,
                                      output logic [127:0] quo, output logic [127:0] rem);
      logic signed [127:0] px, py, pz, nx, ny, nz, num, den;
      logic [127:0] num_mag, den_mag;
      px = $signed(plane_cfg[CSR_ORIGIN_X]) - $signed(r.ox);
      py = $signed(plane_cfg[CSR_ORIGIN_Y]) - $signed(r.oy);
      pz = $signed(plane_cfg[CSR_ORIGIN_Z]) - $signed(r.oz);
      nx = $signed(plane_cfg[CSR_NORMAL_X]);
      ny = $signed(plane_cfg[CSR_NORMAL_Y]);
      nz = $signed(plane_cfg[CSR_NORMAL_Z]);
      num = px * nx + py * ny + pz * nz;
      den = $signed(r.dx) * nx + $signed(r.dy) * ny + $signed(r.dz) * nz;
      den_zero = (den == 0);
      num_zero = (num == 0);
      same_sign = (num < 0) == (den < 0);
      num_mag = (num < 0) ? -num : num;
      den_mag = (den < 0) ? -den : den;
      num_mag = num_mag << FB;
      quo = den_zero ? '0 : num_mag / den_mag;
      rem = den_zero ? '0 : num_mag % den_mag;
   endfunction

   // Expected hit flag and distance for one ray under the current plane.
   function automatic hit_type plane_hit(input ray_type r);
      logic den_zero, num_zero, same_sign, over;
      logic [127:0] quo, rem;
      hit_type res;
      divide_ray(r, den_zero, num_zero, same_sign, quo, rem);
      res.hit = 1'b0;
      res.t_near = '0;
      if (!den_zero) begin
         if (r.op == OP_CLOSEST) begin
            over = (quo > r.tmax) || (quo == r.tmax && rem != 0);
            res.hit = (num_zero || same_sign) && !over;
         end else begin
            res.hit = !num_zero && same_sign && quo < r.tmax;
         end
         if (res.hit) res.t_near = quo[QW-1:0];
      end
      return res;
   endfunction

   function automatic logic [CW-1:0] rand_span(input int unsigned m);
      return int'($urandom_range(2 * m)) - int'(m);
   endfunction

   // A ray with random content; well-formed rays land near the plane with t_max
   // placed on, next to or up to 1 << 16 above the exact distance.
   function automatic ray_type make_ray(input bit well_formed);
      ray_type r;
      logic den_zero, num_zero, same_sign;
      logic [127:0] quo, rem;
      r.op = 1'($urandom_range(1));
      if (!well_formed) begin
         {r.ox, r.oy, r.oz} = {$urandom, $urandom, $urandom};
         {r.dx, r.dy, r.dz} = {$urandom, $urandom, $urandom};
         r.tmax = QW'($urandom);
         return r;
      end
      r.ox = plane_cfg[CSR_ORIGIN_X] + rand_span(1 << 20);
      r.oy = plane_cfg[CSR_ORIGIN_Y] + rand_span(1 << 20);
      r.oz = plane_cfg[CSR_ORIGIN_Z] + rand_span(1 << 20);
      r.dx = rand_span(1 << 18);
      r.dy = rand_span(1 << 18);
      r.dz = ($urandom_range(15) == 0) ? '0 : rand_span(1 << 18);
      r.tmax = QW'($urandom_range(1 << 24));
      divide_ray(r, den_zero, num_zero, same_sign, quo, rem);
      if (!den_zero && quo < 128'h7fff_fffe) begin
         case ($urandom_range(3))
            0: r.tmax = QW'(quo);
            1: r.tmax = QW'(quo + 1);
            2: r.tmax = (quo == 0) ? '0 : QW'(quo - 1);
            default: r.tmax = QW'(quo + $urandom_range(1 << 16));
         endcase
      end
      return r;
   endfunction

   // Driver: offers the oldest pending ray and records its expected result on
   // acceptance. A ray on offer stays on offer until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_hits.push_back(plane_hit(ray_queue[0]));
            void'(ray_queue.pop_front());
         end
         if (req_bus.valid && !req_bus.ready) begin
            req_bus.valid <= 1'b1;
         end else if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid        <= 1'b1;
            req_bus.opcode       <= ray_queue[0].op;
            req_bus.ray_origin_x <= ray_queue[0].ox;
            req_bus.ray_origin_y <= ray_queue[0].oy;
            req_bus.ray_origin_z <= ray_queue[0].oz;
            req_bus.ray_dir_x    <= ray_queue[0].dx;
            req_bus.ray_dir_y    <= ray_queue[0].dy;
            req_bus.ray_dir_z    <= ray_queue[0].dz;
            req_bus.t_max        <= ray_queue[0].tmax;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result item against the oldest expectation and
   // drives ready, including the long hold-off stretches.
   always @(posedge clock) begin
      hit_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_hits.size() == 0) begin
               $error("result item with no ray outstanding");
               fail_count++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_bus.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
                  fail_count++;
               end
               if (rsp_bus.t_near !== want.t_near) begin
                  $error("t_near: expected %0h, got %0h", want.t_near, rsp_bus.t_near);
                  fail_count++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on the run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_plane(input logic [CSR_IDX_W-1:0] idx, input logic [CW-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx <= CSR_NORMAL_Z) plane_cfg[idx] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_ray(input logic op, input logic [CW-1:0] oz, input logic [CW-1:0] dz,
                          input logic [QW-1:0] tmax);
      ray_type r;
      r.op = op;
      {r.ox, r.oy, r.oz} = {32'h0001_0000, 32'hffff_0000, oz};
      {r.dx, r.dy, r.dz} = {32'h0000_4000, 32'hffff_c000, dz};
      r.tmax = tmax;
      ray_queue.push_back(r);
   endtask

   // Waits until every ray is taken and answered, then lets the pipe settle.
   task automatic wait_drained();
      while (ray_queue.size() > 0 || expected_hits.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int sidle, input int ridle, input bit hold);
      @(negedge clock);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < count; i++) ray_queue.push_back(make_ray($urandom_range(3) != 0));
      if (hold) begin
         repeat (20) @(negedge clock);
         hold_requests++;
      end
      wait_drained();
   endtask

   // Reset, then phases of rays under several plane settings.
   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = 1'b0;
      {req_bus.ray_origin_x, req_bus.ray_origin_y, req_bus.ray_origin_z} = '0;
      {req_bus.ray_dir_x, req_bus.ray_dir_y, req_bus.ray_dir_z} = '0;
      req_bus.t_max = '0;
      rsp_bus.ready = 1'b0;
      plane_cfg[CSR_ORIGIN_X] = '0;
      plane_cfg[CSR_ORIGIN_Y] = '0;
      plane_cfg[CSR_ORIGIN_Z] = '0;
      plane_cfg[CSR_NORMAL_X] = '0;
      plane_cfg[CSR_NORMAL_Y] = '0;
      plane_cfg[CSR_NORMAL_Z] = 32'h0001_0000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rays under the reset plane z = 0 with unit normal along z.
      @(negedge clock);
      send_idle_pct = 18;
      recv_idle_pct = 54;
      add_ray(OP_CLOSEST,   32'h0,          32'h0001_0000, 31'h0);          // origin on plane
      add_ray(OP_OCCLUSION, 32'h0,          32'h0001_0000, 31'h0000_1000);
      add_ray(OP_CLOSEST,   32'hfffb_0000,  32'h0001_0000, 31'h0005_0000);  // t equals t_max
      add_ray(OP_OCCLUSION, 32'hfffb_0000,  32'h0001_0000, 31'h0005_0000);
      add_ray(OP_OCCLUSION, 32'hfffb_0000,  32'h0001_0000, 31'h0005_0001);
      add_ray(OP_CLOSEST,   32'hfffb_0000,  32'h0000_0000, 31'h7fff_ffff);  // parallel
      add_ray(OP_OCCLUSION, 32'hfffb_0000,  32'h0000_0000, 31'h7fff_ffff);
      add_ray(OP_CLOSEST,   32'h0001_0000,  32'h0001_0000, 31'h7fff_ffff);  // behind origin
      add_ray(OP_CLOSEST,   32'h8000_0000,  32'h0000_0001, 31'h7fff_ffff);  // quotient overflow
      add_ray(OP_OCCLUSION, 32'h8000_0000,  32'h0000_0001, 31'h7fff_ffff);
      add_ray(OP_CLOSEST,   32'h7fff_ffff,  32'h8000_0000, 31'h7fff_ffff);
      add_ray(OP_OCCLUSION, 32'h7fff_ffff,  32'h8000_0000, 31'h0);
      add_ray(OP_CLOSEST,   32'hffff_ffff,  32'h0000_0003, 31'd21845);      // remainder past t_max
      add_ray(OP_CLOSEST,   32'hffff_ffff,  32'h0000_0003, 31'd21846);
      add_ray(OP_OCCLUSION, 32'hffff_ffff,  32'h0000_0003, 31'd21845);
      add_ray(OP_CLOSEST,   32'h8000_0000,  32'h7fff_ffff, 31'h7fff_ffff);
      add_ray(OP_CLOSEST,   32'hffff_0000,  32'hffff_ffff, 31'h7fff_ffff);  // both negative
      wait_drained();
      run_phase(280, 18, 54, 1'b0);

      // Small random plane, with a long receiver hold-off.
      write_plane(CSR_ORIGIN_X, rand_span(1 << 22));
      write_plane(CSR_ORIGIN_Y, rand_span(1 << 22));
      write_plane(CSR_ORIGIN_Z, rand_span(1 << 22));
      write_plane(CSR_NORMAL_X, rand_span(1 << 17));
      write_plane(CSR_NORMAL_Y, rand_span(1 << 17));
      write_plane(CSR_NORMAL_Z, rand_span(1 << 17));
      write_plane(CSR_UNUSED_IDX, 32'hdead_beef);
      run_phase(290, 18, 54, 1'b1);

      // Extreme plane.
      write_plane(CSR_ORIGIN_X, 32'h7fff_ffff);
      write_plane(CSR_ORIGIN_Y, 32'h8000_0000);
      write_plane(CSR_ORIGIN_Z, 32'h7fff_ffff);
      write_plane(CSR_NORMAL_X, 32'h8000_0000);
      write_plane(CSR_NORMAL_Y, 32'h7fff_ffff);
      write_plane(CSR_NORMAL_Z, 32'h8000_0000);
      run_phase(290, 54, 18, 1'b0);

      // Zero normal: every denominator vanishes.
      write_plane(CSR_NORMAL_X, '0);
      write_plane(CSR_NORMAL_Y, '0);
      write_plane(CSR_NORMAL_Z, '0);
      run_phase(150, 54, 18, 1'b0);

      // Fully random plane, then no idling at all.
      for (int i = 0; i < 6; i++) write_plane(CSR_IDX_W'(i), $urandom);
      run_phase(140, 54, 18, 1'b0);
      for (int i = 0; i < 6; i++) begin
         write_plane(CSR_IDX_W'(i), (i < 3) ? $urandom : rand_span(1 << 16));
      end
      run_phase(300, 0, 0, 1'b0);

      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
